// File: hdl/sunf_pkg.sv
// Package for the scan unflatness block: request payload types, sequencer
// states, fixed-point constants and the rotation arctangent table.
// Used by hdl/scan_unflatness.sv; depends on nothing else.
package sunf_pkg;

    // Input request: one range sample and its end-of-scan mark
    typedef struct packed {
        logic [15:0] range_sample;
        logic        scan_end;
    } sample_t;

    // Output request: one unflatness value and its end-of-scan mark
    typedef struct packed {
        logic [15:0] unflatness;
        logic        result_last;
    } result_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GAIN,
        ST_ROT_LOAD,
        ST_ROTATE,
        ST_POINT,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_DIV_X_LOAD,
        ST_DIV_X,
        ST_DIV_Y_LOAD,
        ST_DIV_Y,
        ST_DOT_X,
        ST_DOT_Y,
        ST_DOT_SUM,
        ST_EMIT_A,
        ST_EMIT_B
    } state_t;

    // Register word index of angle_step (byte address 0)
    localparam logic [0:0] RegAngleStep = 1'b0;

    // Quadrant codes taken from the top two angle bits
    localparam logic [1:0] Quad0 = 2'd0;
    localparam logic [1:0] Quad1 = 2'd1;
    localparam logic [1:0] Quad2 = 2'd2;

    // Fixed-point constants
    localparam logic [16:0]        CordicGain = 17'd39797;   // 0.60725 in Q16
    localparam logic signed [27:0] CoordMax   = 28'sd131071;
    localparam logic signed [27:0] CoordMin   = -28'sd131071;
    localparam logic signed [27:0] CoordRound = 28'sd128;
    localparam logic [15:0]        UnitOne    = 16'd16384;   // 1.0 in Q14
    localparam logic [19:0]        UnflatMax  = 20'd32768;   // 2.0 in Q14
    localparam logic signed [33:0] UnflatBias = 34'sd268443648; // 2^28 + half LSB

    // Rotation arctangent table, units of 2*pi / 2^24
    function automatic logic signed [24:0] arc_entry(input logic [3:0] idx);
        logic signed [24:0] val;
        case (idx)
            4'd0:    val = 25'sd2097152;
            4'd1:    val = 25'sd1238021;
            4'd2:    val = 25'sd654136;
            4'd3:    val = 25'sd332050;
            4'd4:    val = 25'sd166669;
            4'd5:    val = 25'sd83416;
            4'd6:    val = 25'sd41718;
            4'd7:    val = 25'sd20860;
            4'd8:    val = 25'sd10430;
            4'd9:    val = 25'sd5215;
            4'd10:   val = 25'sd2608;
            4'd11:   val = 25'sd1304;
            4'd12:   val = 25'sd652;
            4'd13:   val = 25'sd326;
            4'd14:   val = 25'sd163;
            default: val = 25'sd81;
        endcase
        return val;
    endfunction

endpackage

// File: hdl/scan_unflatness.sv
// Scan unflatness block: iterative rotation, square root and division under
// one sequencer, with a two-entry result queue.
// Depends on hdl/sunf_pkg.sv.
//
// Usage
//   sample channel: one range sample per request (sample_valid / sample_stall).
//   result channel: unflatness requests (result_valid / result_stall).
//   APB port: register angle_step at byte address 0, written between scans or
//   while the block is idle.
// Sequencing
//   A sample is taken only while the sequencer is idle and holds the block
//   until its results are queued. The work is the 16-step rotation, the
//   32-step root (one bit a cycle) and two 16-step divisions, run one after
//   the other on the same sequencer. Results trail by one sample; the sample
//   that ends a scan gives two, or one if it is its scan's only sample.
// Reset
//   Clears the phase, point history, angle_step and the result queue.
// Stall
//   Results wait in a two-entry queue; when it is full the sequencer holds
//   in its emit states, so nothing is lost, and sample_stall stays high.
module scan_unflatness (
    input  logic                 clk,
    input  logic                 rst_n,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Sample channel
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sunf_pkg::sample_t    sample,
    // Result channel
    output logic                 result_valid,
    input  logic                 result_stall,
    output sunf_pkg::result_t    result
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    sunf_pkg::state_t state_reg, state_next;

    logic [4:0]  step_reg;
    logic [15:0] angle_step_reg;
    logic [15:0] phase_reg;
    logic [1:0]  points_reg;
    logic signed [17:0] prior_x_reg, prior_y_reg;
    logic signed [15:0] prior_ux_reg, prior_uy_reg;

    // datapath
    logic [15:0] range_reg;
    logic        last_reg;
    logic signed [39:0] prod_reg;
    logic signed [26:0] c_reg, s_reg;
    logic signed [24:0] z_reg;
    logic signed [17:0] px_reg, py_reg;
    logic [37:0] n_reg;
    logic [63:0] m_reg;
    logic [33:0] rt_rem_reg;
    logic [31:0] root_reg;
    logic [31:0] div_rem_reg;
    logic [15:0] div_low_reg;
    logic [15:0] div_q_reg;
    logic        div_neg_reg;
    logic signed [15:0] ux_reg, uy_reg;
    logic signed [31:0] acc_reg;

    // result queue
    sunf_pkg::result_t fifo_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       fifo_full;
    logic       pop;

    // sequencer outputs
    logic              accept;
    logic              push_en;
    sunf_pkg::result_t push_data;
    logic              scan_done;
    logic signed [19:0] mul_a, mul_b;
    logic signed [39:0] mul_p;
    logic              div_sel_y;

    // combinational helpers
    logic signed [18:0] dx, dy;
    logic               seg_zero;
    logic [3:0]         rot_idx;
    logic signed [26:0] c_shr, s_shr;
    logic signed [24:0] arc;
    logic signed [27:0] ox, oy, rx, ry;
    logic signed [17:0] px_new, py_new;
    logic [35:0]        rt_in, rt_trial, rt_diff;
    logic               rt_ge;
    logic signed [18:0] div_d, div_mag_full;
    logic [45:0]        div_numer;
    logic [32:0]        div_in, div_diff;
    logic               div_ge;
    logic [15:0]        q_full, q_clamped;
    logic signed [15:0] u_val;
    logic signed [33:0] unflat_v;
    logic [19:0]        unflat_t;
    logic [15:0]        unflat_val;
    logic               wr_cfg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[2:2] == sunf_pkg::RegAngleStep)
            prdata = {16'd0, angle_step_reg};
        else
            prdata = 32'd0;
    end

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Rotation step and point forming
    // ------------------------------------------------------------------
    assign rot_idx = step_reg[3:0];
    assign c_shr   = c_reg >>> rot_idx;
    assign s_shr   = s_reg >>> rot_idx;
    assign arc     = sunf_pkg::arc_entry(rot_idx);

    // quadrant map
    always_comb
    begin
        case (phase_reg[15:14])
            sunf_pkg::Quad0:
            begin
                ox = 28'(c_reg);
                oy = 28'(s_reg);
            end
            sunf_pkg::Quad1:
            begin
                ox = -28'(s_reg);
                oy = 28'(c_reg);
            end
            sunf_pkg::Quad2:
            begin
                ox = -28'(c_reg);
                oy = -28'(s_reg);
            end
            default:
            begin
                ox = 28'(s_reg);
                oy = -28'(c_reg);
            end
        endcase
    end

    assign rx = (ox + sunf_pkg::CoordRound) >>> 8;
    assign ry = (oy + sunf_pkg::CoordRound) >>> 8;

    // clamp to the coordinate range
    always_comb
    begin
        if (rx > sunf_pkg::CoordMax)
            px_new = 18'(sunf_pkg::CoordMax);
        else if (rx < sunf_pkg::CoordMin)
            px_new = 18'(sunf_pkg::CoordMin);
        else
            px_new = 18'(rx);
        if (ry > sunf_pkg::CoordMax)
            py_new = 18'(sunf_pkg::CoordMax);
        else if (ry < sunf_pkg::CoordMin)
            py_new = 18'(sunf_pkg::CoordMin);
        else
            py_new = 18'(ry);
    end

    // segment from the prior point
    assign dx       = 19'(px_reg) - 19'(prior_x_reg);
    assign dy       = 19'(py_reg) - 19'(prior_y_reg);
    assign seg_zero = (dx == 19'sd0) && (dy == 19'sd0);

    // ------------------------------------------------------------------
    // Square root step: one result bit per cycle
    // ------------------------------------------------------------------
    assign rt_in    = {rt_rem_reg, m_reg[63:62]};
    assign rt_trial = {2'b00, root_reg, 2'b01};
    assign rt_ge    = (rt_in >= rt_trial);
    assign rt_diff  = rt_in - rt_trial;

    // ------------------------------------------------------------------
    // Division step: one quotient bit per cycle
    // ------------------------------------------------------------------
    assign div_d        = div_sel_y ? dy : dx;
    assign div_mag_full = div_d[18] ? -div_d : div_d;
    assign div_numer    = {1'b0, div_mag_full[17:0], 27'd0} + {15'd0, root_reg[31:1]};

    assign div_in   = {div_rem_reg, div_low_reg[15]};
    assign div_ge   = (div_in >= {1'b0, root_reg});
    assign div_diff = div_in - {1'b0, root_reg};

    assign q_full    = {div_q_reg[14:0], div_ge};
    assign q_clamped = (q_full > sunf_pkg::UnitOne) ? sunf_pkg::UnitOne : q_full;
    assign u_val     = div_neg_reg ? -signed'(q_clamped) : signed'(q_clamped);

    // ------------------------------------------------------------------
    // Unflatness from the dot product
    // ------------------------------------------------------------------
    assign unflat_v = sunf_pkg::UnflatBias - 34'(acc_reg);
    assign unflat_t = unflat_v[33:14];

    always_comb
    begin
        if (unflat_v[33])
            unflat_val = 16'd0;
        else if (unflat_t > sunf_pkg::UnflatMax)
            unflat_val = 16'(sunf_pkg::UnflatMax);
        else
            unflat_val = unflat_t[15:0];
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sunf_pkg::ST_IDLE:
            begin
                if (sample_valid)
                    state_next = sunf_pkg::ST_GAIN;
            end
            sunf_pkg::ST_GAIN:     state_next = sunf_pkg::ST_ROT_LOAD;
            sunf_pkg::ST_ROT_LOAD: state_next = sunf_pkg::ST_ROTATE;
            sunf_pkg::ST_ROTATE:
            begin
                if (step_reg == 5'd15)
                    state_next = sunf_pkg::ST_POINT;
            end
            sunf_pkg::ST_POINT:    state_next = sunf_pkg::ST_SQ_X;
            sunf_pkg::ST_SQ_X:
            begin
                if (points_reg == 2'd0)
                    state_next = sunf_pkg::ST_EMIT_A;
                else if (seg_zero)
                    state_next = (points_reg == 2'd2) ? sunf_pkg::ST_DOT_X
                                                      : sunf_pkg::ST_EMIT_A;
                else
                    state_next = sunf_pkg::ST_SQ_Y;
            end
            sunf_pkg::ST_SQ_Y:     state_next = sunf_pkg::ST_ROOT_LOAD;
            sunf_pkg::ST_ROOT_LOAD: state_next = sunf_pkg::ST_ROOT;
            sunf_pkg::ST_ROOT:
            begin
                if (step_reg == 5'd31)
                    state_next = sunf_pkg::ST_DIV_X_LOAD;
            end
            sunf_pkg::ST_DIV_X_LOAD: state_next = sunf_pkg::ST_DIV_X;
            sunf_pkg::ST_DIV_X:
            begin
                if (step_reg == 5'd15)
                    state_next = sunf_pkg::ST_DIV_Y_LOAD;
            end
            sunf_pkg::ST_DIV_Y_LOAD: state_next = sunf_pkg::ST_DIV_Y;
            sunf_pkg::ST_DIV_Y:
            begin
                if (step_reg == 5'd15)
                    state_next = (points_reg == 2'd2) ? sunf_pkg::ST_DOT_X
                                                      : sunf_pkg::ST_EMIT_A;
            end
            sunf_pkg::ST_DOT_X:   state_next = sunf_pkg::ST_DOT_Y;
            sunf_pkg::ST_DOT_Y:   state_next = sunf_pkg::ST_DOT_SUM;
            sunf_pkg::ST_DOT_SUM: state_next = sunf_pkg::ST_EMIT_A;
            sunf_pkg::ST_EMIT_A:
            begin
                if (!((points_reg != 2'd0) && fifo_full))
                    state_next = sunf_pkg::ST_EMIT_B;
            end
            sunf_pkg::ST_EMIT_B:
            begin
                if (!(last_reg && fifo_full))
                    state_next = sunf_pkg::ST_IDLE;
            end
            default:               state_next = sunf_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        accept       = 1'b0;
        sample_stall = 1'b1;
        push_en      = 1'b0;
        push_data    = '0;
        scan_done    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_sel_y    = 1'b0;
        case (state_reg)
            sunf_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                accept       = sample_valid;
            end
            sunf_pkg::ST_GAIN:
            begin
                mul_a = signed'({4'd0, range_reg});
                mul_b = signed'({3'd0, sunf_pkg::CordicGain});
            end
            sunf_pkg::ST_SQ_X:
            begin
                mul_a = 20'(dx);
                mul_b = 20'(dx);
            end
            sunf_pkg::ST_SQ_Y:
            begin
                mul_a = 20'(dy);
                mul_b = 20'(dy);
            end
            sunf_pkg::ST_DIV_Y_LOAD:
            begin
                div_sel_y = 1'b1;
            end
            sunf_pkg::ST_DOT_X:
            begin
                mul_a = 20'(prior_ux_reg);
                mul_b = 20'(ux_reg);
            end
            sunf_pkg::ST_DOT_Y:
            begin
                mul_a = 20'(prior_uy_reg);
                mul_b = 20'(uy_reg);
            end
            sunf_pkg::ST_EMIT_A:
            begin
                push_en = (points_reg != 2'd0) && !fifo_full;
                push_data.unflatness  = (points_reg == 2'd1) ? 16'd0 : unflat_val;
                push_data.result_last = 1'b0;
            end
            sunf_pkg::ST_EMIT_B:
            begin
                push_en   = last_reg && !fifo_full;
                scan_done = !(last_reg && fifo_full);
                push_data.unflatness  = 16'd0;
                push_data.result_last = 1'b1;
            end
            default:
            begin
                accept = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sunf_pkg::ST_IDLE;
            step_reg       <= '0;
            angle_step_reg <= '0;
            phase_reg      <= '0;
            points_reg     <= '0;
            prior_x_reg    <= '0;
            prior_y_reg    <= '0;
            prior_ux_reg   <= '0;
            prior_uy_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // iteration counter
            if (state_reg == sunf_pkg::ST_ROT_LOAD || state_reg == sunf_pkg::ST_ROOT_LOAD
                || state_reg == sunf_pkg::ST_DIV_X_LOAD
                || state_reg == sunf_pkg::ST_DIV_Y_LOAD)
                step_reg <= '0;
            else if (state_reg == sunf_pkg::ST_ROTATE || state_reg == sunf_pkg::ST_ROOT
                     || state_reg == sunf_pkg::ST_DIV_X || state_reg == sunf_pkg::ST_DIV_Y)
                step_reg <= step_reg + 5'd1;

            if (wr_cfg && paddr[2:2] == sunf_pkg::RegAngleStep)
                angle_step_reg <= pwdata[15:0];

            // scan history update once the request's results are queued
            if (scan_done)
            begin
                if (last_reg)
                begin
                    phase_reg    <= '0;
                    points_reg   <= '0;
                    prior_x_reg  <= '0;
                    prior_y_reg  <= '0;
                    prior_ux_reg <= '0;
                    prior_uy_reg <= '0;
                end
                else
                begin
                    phase_reg    <= phase_reg + angle_step_reg;
                    prior_x_reg  <= px_reg;
                    prior_y_reg  <= py_reg;
                    prior_ux_reg <= ux_reg;
                    prior_uy_reg <= uy_reg;
                    if (points_reg != 2'd2)
                        points_reg <= points_reg + 2'd1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            range_reg <= sample.range_sample;
            last_reg  <= sample.scan_end;
            ux_reg    <= '0;
            uy_reg    <= '0;
        end

        // multiplier result register
        if (state_reg == sunf_pkg::ST_GAIN || state_reg == sunf_pkg::ST_SQ_X
            || state_reg == sunf_pkg::ST_SQ_Y || state_reg == sunf_pkg::ST_DOT_X
            || state_reg == sunf_pkg::ST_DOT_Y)
            prod_reg <= mul_p;

        case (state_reg)
            sunf_pkg::ST_ROT_LOAD:
            begin
                c_reg <= signed'({3'd0, prod_reg[31:8]});
                s_reg <= '0;
                z_reg <= signed'({3'd0, phase_reg[13:0], 8'd0});
            end
            sunf_pkg::ST_ROTATE:
            begin
                if (!z_reg[24])
                begin
                    c_reg <= c_reg - s_shr;
                    s_reg <= s_reg + c_shr;
                    z_reg <= z_reg - arc;
                end
                else
                begin
                    c_reg <= c_reg + s_shr;
                    s_reg <= s_reg - c_shr;
                    z_reg <= z_reg + arc;
                end
            end
            sunf_pkg::ST_POINT:
            begin
                px_reg <= px_new;
                py_reg <= py_new;
            end
            sunf_pkg::ST_SQ_Y:
            begin
                n_reg <= prod_reg[37:0];
            end
            sunf_pkg::ST_ROOT_LOAD:
            begin
                m_reg      <= {n_reg + prod_reg[37:0], 26'd0};
                rt_rem_reg <= '0;
                root_reg   <= '0;
            end
            sunf_pkg::ST_ROOT:
            begin
                m_reg <= {m_reg[61:0], 2'b00};
                if (rt_ge)
                begin
                    rt_rem_reg <= rt_diff[33:0];
                    root_reg   <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rt_rem_reg <= rt_in[33:0];
                    root_reg   <= {root_reg[30:0], 1'b0};
                end
            end
            sunf_pkg::ST_DIV_X_LOAD, sunf_pkg::ST_DIV_Y_LOAD:
            begin
                div_rem_reg <= {2'd0, div_numer[45:16]};
                div_low_reg <= div_numer[15:0];
                div_q_reg   <= '0;
                div_neg_reg <= div_d[18];
            end
            sunf_pkg::ST_DIV_X, sunf_pkg::ST_DIV_Y:
            begin
                div_rem_reg <= div_ge ? div_diff[31:0] : div_in[31:0];
                div_low_reg <= {div_low_reg[14:0], 1'b0};
                div_q_reg   <= q_full;
                if (step_reg == 5'd15)
                begin
                    if (state_reg == sunf_pkg::ST_DIV_X)
                        ux_reg <= u_val;
                    else
                        uy_reg <= u_val;
                end
            end
            sunf_pkg::ST_DOT_Y:
            begin
                acc_reg <= prod_reg[31:0];
            end
            sunf_pkg::ST_DOT_SUM:
            begin
                acc_reg <= acc_reg + prod_reg[31:0];
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result queue, two entries
    // ------------------------------------------------------------------
    assign fifo_full    = (count_reg == 2'd2);
    assign result_valid = (count_reg != 2'd0);
    assign result       = fifo_mem[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;

    always_ff @(posedge clk)
    begin
        if (push_en)
            fifo_mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push_en && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push_en)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// File: sim/scan_unflatness_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for scan_unflatness: directed scans, then random scans at
// several angle_step settings, with random idling and one long result hold-off.
// Depends on hdl/sunf_pkg.sv and hdl/scan_unflatness.sv.
module scan_unflatness_tb;

    localparam int          SettleCycles  = 120;   // longer than one sample's work
    localparam int          HoldCycles    = 600;   // long result hold-off
    localparam int          HoldAt        = 150;   // result count that starts it
    localparam int          WatchdogLimit = 4000;
    localparam int          PhaseItems    = 215;
    localparam logic [2:0]  AngleStepAddr = {sunf_pkg::RegAngleStep, 2'b00};

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [2:0]          paddr        = '0;
    logic [31:0]         pwdata       = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    sunf_pkg::sample_t   sample       = '0;
    logic                result_valid;
    logic                result_stall = 1'b1;
    sunf_pkg::result_t   result;

    // Unflatness predictor with its own copy of the block's state
    class unflat_tracker;
        sunf_pkg::result_t  pending[$];
        int                 failures = 0;
        int                 checked  = 0;
        int                 samples  = 0;
        int                 scans    = 0;
        logic [15:0]        angle_inc = '0;
        logic [15:0]        phase     = '0;
        logic signed [17:0] last_x    = '0;
        logic signed [17:0] last_y    = '0;
        logic signed [15:0] last_ux   = '0;
        logic signed [15:0] last_uy   = '0;
        logic [1:0]         seen      = '0;
        longint             arc_tab[16] = '{2097152, 1238021, 654136, 332050, 166669,
                                            83416, 41718, 20860, 10430, 5215, 2608,
                                            1304, 652, 326, 163, 81};

        function longint limit_coord(input longint v);
            if (v > 131071)
                return 131071;
            if (v < -131071)
                return -131071;
            return v;
        endfunction

        // Range and angle to x, y in range units by 16-step rotation
        function void polar_to_xy(input logic [15:0] r, input logic [15:0] ang,
                                  output longint px, output longint py);
            longint c, s, z, tc, ts, ox, oy;
            c = (longint'(r) * 39797) >>> 8;
            s = 0;
            z = longint'(ang[13:0]) << 8;
            for (int i = 0; i < 16; i++)
            begin
                ts = s >>> i;
                tc = c >>> i;
                if (z >= 0)
                begin
                    c = c - ts;
                    s = s + tc;
                    z = z - arc_tab[i];
                end
                else
                begin
                    c = c + ts;
                    s = s - tc;
                    z = z + arc_tab[i];
                end
            end
            case (ang[15:14])
                sunf_pkg::Quad0: begin ox = c;  oy = s;  end
                sunf_pkg::Quad1: begin ox = -s; oy = c;  end
                sunf_pkg::Quad2: begin ox = -c; oy = -s; end
                default:         begin ox = s;  oy = -c; end
            endcase
            px = limit_coord((ox + 128) >>> 8);
            py = limit_coord((oy + 128) >>> 8);
        endfunction

        // Floor of the square root, digit by digit
        function longint unsigned isqrt(input longint unsigned n);
            longint unsigned root, bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= root + bitv)
                begin
                    n    = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        // One Q14 component of a unit segment, rounded half up, at most 1.0
        function longint unit_comp(input longint d, input longint unsigned len);
            longint unsigned mag, q;
            mag = (d < 0) ? -d : d;
            q   = ((mag << 27) + len / 2) / len;
            if (q > 16384)
                q = 16384;
            return (d < 0) ? -longint'(q) : longint'(q);
        endfunction

        function logic [15:0] unflat_val(input longint ax, input longint ay,
                                         input longint bx, input longint by);
            longint v;
            v = (longint'(1) << 28) - (ax * bx + ay * by) + 8192;
            if (v < 0)
                return '0;
            v = v >>> 14;
            if (v > 32768)
                v = 32768;
            return v[15:0];
        endfunction

        function void queue_result(input logic [15:0] u, input logic last);
            sunf_pkg::result_t res;
            res.unflatness  = u;
            res.result_last = last;
            pending.insert(pending.size(), res);
        endfunction

        // Accepted sample: advance the state and queue what it gives
        function void take_sample(input sunf_pkg::sample_t smp);
            longint          px, py, ux, uy, dx, dy;
            longint unsigned n, len;
            samples++;
            polar_to_xy(smp.range_sample, phase, px, py);
            ux = 0;
            uy = 0;
            if (seen >= 1)
            begin
                dx = px - last_x;
                dy = py - last_y;
                n  = dx * dx + dy * dy;
                if (n != 0)
                begin
                    len = isqrt(n << 26);
                    ux  = unit_comp(dx, len);
                    uy  = unit_comp(dy, len);
                end
            end
            if (seen == 1)
                queue_result('0, 1'b0);
            else if (seen >= 2)
                queue_result(unflat_val(last_ux, last_uy, ux, uy), 1'b0);
            if (smp.scan_end)
            begin
                queue_result('0, 1'b1);
                scans++;
                phase   = '0;
                seen    = '0;
                last_x  = '0;
                last_y  = '0;
                last_ux = '0;
                last_uy = '0;
            end
            else
            begin
                last_x  = px[17:0];
                last_y  = py[17:0];
                last_ux = ux[15:0];
                last_uy = uy[15:0];
                if (seen < 2)
                    seen++;
                phase = phase + angle_inc;
            end
        endfunction

        // Accepted result against the oldest expectation
        function void match_result(input sunf_pkg::result_t got);
            sunf_pkg::result_t want;
            checked++;
            if (pending.size() == 0)
            begin
                failures++;
                $error("unexpected result: unflatness %0d result_last %0b",
                       got.unflatness, got.result_last);
                return;
            end
            want = pending.pop_front();
            if (got.unflatness !== want.unflatness)
            begin
                failures++;
                $error("unflatness: expected %0d, actual %0d", want.unflatness,
                       got.unflatness);
            end
            if (got.result_last !== want.result_last)
            begin
                failures++;
                $error("result_last: expected %0b, actual %0b", want.result_last,
                       got.result_last);
            end
        endfunction
    endclass

    unflat_tracker       tracker;
    sunf_pkg::sample_t   sample_plan[$];
    int                  settings     = 0;
    int                  received     = 0;
    int                  quiet_cycles = 0;
    logic                send_burst   = 1'b0;
    logic                recv_burst   = 1'b0;
    logic [15:0]         step_list[6];

    scan_unflatness dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: too long without any request moving
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WatchdogLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off
    initial
    begin
        int gap;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_burst = ~recv_burst;
            if (received == HoldAt)
                gap = HoldCycles;
            else
                gap = recv_burst ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            tracker.match_result(result);
            received++;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one sample request after a random gap, return once it is taken
    task automatic send_sample(input sunf_pkg::sample_t smp);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= smp;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        tracker.take_sample(smp);
    endtask

    task automatic add_item(input logic [15:0] r, input logic last);
        sunf_pkg::sample_t smp;
        smp.range_sample = r;
        smp.scan_end     = last;
        sample_plan.insert(sample_plan.size(), smp);
    endtask

    // One random scan: noise, smooth walk, repeated values or extremes
    task automatic plan_scan();
        int          len, style;
        logic [15:0] r;
        len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
        style = $urandom_range(0, 3);
        r     = 16'($urandom);
        for (int k = 0; k < len; k++)
        begin
            case (style)
                0: r = 16'($urandom);
                1: r = r + 16'($urandom_range(0, 512)) - 16'd256;
                2: if ($urandom_range(0, 3) == 0) r = 16'($urandom);
                default:
                    if ($urandom_range(0, 1) == 1)
                        r = 16'hFFFF;
                    else
                        r = ($urandom_range(0, 1) == 1) ? 16'h0000 : 16'($urandom);
            endcase
            add_item(r, k == len - 1);
        end
    endtask

    // Set angle_step while idle, play the plan, drain and settle
    task automatic play_phase(input logic [15:0] angle_inc);
        write_reg(AngleStepAddr, {16'd0, angle_inc});
        tracker.angle_inc = angle_inc;
        settings++;
        while (sample_plan.size() != 0)
            send_sample(sample_plan.pop_front());
        sample_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    initial
    begin
        tracker = new;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, quarter turn per sample: one-sample scans, two-sample scan,
        // all points at the origin, full-range loop, spike to zero
        add_item(16'h0000, 1'b1);
        add_item(16'hFFFF, 1'b1);
        add_item(16'd256, 1'b0);
        add_item(16'hFFFF, 1'b1);
        repeat (4) add_item(16'h0000, 1'b0);
        add_item(16'h0000, 1'b1);
        repeat (4) add_item(16'hFFFF, 1'b0);
        add_item(16'hFFFF, 1'b1);
        add_item(16'd1000, 1'b0);
        add_item(16'h0000, 1'b0);
        add_item(16'd1000, 1'b1);
        play_phase(16'd16384);

        // Directed, no rotation: zero-length segments, then a straight line
        add_item(16'd500, 1'b0);
        add_item(16'd500, 1'b0);
        add_item(16'd500, 1'b1);
        add_item(16'd100, 1'b0);
        add_item(16'd200, 1'b0);
        add_item(16'd300, 1'b1);
        play_phase(16'd0);

        // Random scans over a spread of angle steps, extremes included
        step_list[0] = 16'hFFFF;
        step_list[1] = 16'd1;
        step_list[2] = 16'd32768;
        step_list[3] = 16'($urandom);
        step_list[4] = 16'($urandom_range(100, 3000));
        step_list[5] = 16'd0;
        for (int p = 0; p < 6; p++)
        begin
            while (sample_plan.size() < PhaseItems)
                plan_scan();
            play_phase(step_list[p]);
        end

        if (tracker.pending.size() != 0)
        begin
            tracker.failures++;
            $error("%0d expected results never arrived", tracker.pending.size());
        end
        $display("Run covered %0d samples in %0d scans over %0d angle_step settings.",
                 tracker.samples, tracker.scans, settings);
        $display("%0d results compared, %0d mismatches.", tracker.checked,
                 tracker.failures);
        if (tracker.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/sunf_pkg.sv
hdl/scan_unflatness.sv
sim/scan_unflatness_tb.sv
